@@ hw/rtl/lfu_pkg.sv @@
package lfu_pkg;

   localparam int Entries = 16;
   localparam int IdxW = $clog2(Entries);
   localparam int CntW = $clog2(Entries + 1);
   localparam int CapW = 5;
   localparam int KeyW = 32;
   localparam int DatW = 32;
   localparam int UseW = 32;
   localparam int StampW = 64;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   localparam logic [CapW-1:0] CAP_RESET = CapW'(16);
   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic             operation;
      logic [KeyW-1:0]  key;
      logic [DatW-1:0]  value;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [DatW-1:0]  read_value;
   } rsp_type;

   // One row of the entry memory.
   typedef struct packed {
      logic [KeyW-1:0]   key;
      logic [DatW-1:0]   data;
      logic [UseW-1:0]   count;
      logic [StampW-1:0] stamp;
   } entry_type;

endpackage

@@ hw/rtl/lfu_if.sv @@
interface lfu_req_if;
   import lfu_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lfu_rsp_if;
   import lfu_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/lfu_csr.sv @@
module lfu_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [1:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output logic [lfu_pkg::CapW-1:0] capacity
);
   import lfu_pkg::*;

   logic [CapW-1:0] capacity_ff;
   logic            write_hit;

   // The only register sits at byte address zero.
   assign write_hit = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[1:0] == {REG_CAPACITY, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (write_hit) begin
         capacity_ff <= csr_pwdata[CapW-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == {REG_CAPACITY, 1'b0}) ?
                       {{(32-CapW){1'b0}}, capacity_ff} : 32'd0;
   assign capacity = capacity_ff;
endmodule

@@ hw/rtl/lfu_cache_lru_tiebreak.sv @@
// Sequence: a request is accepted only in S_IDLE; S_SCAN sweeps the single read port of the
// entry memory one entry per cycle for the key match and victim search; S_WRITE updates the
// entry; S_RESP holds the response until it is taken. A new request is not accepted until the
// response of the last one has been taken.
// Reset: synchronous, active high; clears valid bits, use clock, occupancy and capacity
// (to 16). The entry memory itself is not cleared; valid bits mask it.
module lfu_cache_lru_tiebreak (
   input  logic        clock,
   input  logic        reset,
   lfu_req_if.sink     req,
   lfu_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lfu_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_RESP} state_type;

   logic [CapW-1:0] capacity;

   lfu_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .capacity
   );

   // Entry memory: one write port, one registered read port.
   entry_type mem [Entries];
   entry_type rd_data_ff;
   logic [IdxW-1:0] rd_addr;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   entry_type       wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   state_type         state_ff;
   logic [Entries-1:0] valid_ff;
   logic [StampW-1:0] clock_ff;
   logic [CntW-1:0]   occ_ff;
   req_type           req_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic [IdxW:0]     addr_ff;       // issue pointer, one past while draining
   logic [IdxW:0]     chk_ff;        // index of the word in rd_data_ff
   logic              chk_valid_ff;
   logic              found_ff;
   logic [IdxW-1:0]   found_idx_ff;
   entry_type         found_ent_ff;
   logic              vic_ok_ff;
   logic [IdxW-1:0]   vic_idx_ff;
   logic [UseW-1:0]   vic_cnt_ff;
   logic [StampW-1:0] vic_stamp_ff;

   logic [CntW-1:0]   eff_cap;
   logic [IdxW-1:0]   chk_idx;
   logic              chk_live;
   logic              better;

   assign rd_addr = addr_ff[IdxW-1:0];
   assign chk_idx = chk_ff[IdxW-1:0];
   assign chk_live = chk_valid_ff && valid_ff[chk_idx];
   assign better = !vic_ok_ff || (rd_data_ff.count < vic_cnt_ff)
                   || (rd_data_ff.count == vic_cnt_ff && rd_data_ff.stamp < vic_stamp_ff);

   // Effective capacity clamped to 1..Entries.
   always_comb begin
      if (capacity == '0) eff_cap = CntW'(1);
      else if (32'(capacity) > Entries) eff_cap = CntW'(Entries);
      else eff_cap = CntW'(capacity);
   end

   // Placement of a new entry: lowest free slot, with the victim freed when evicting.
   logic [Entries-1:0] free_mask;
   logic               free_ok;
   logic [IdxW-1:0]    free_idx;
   logic               evict;

   assign evict = vic_ok_ff && (occ_ff >= eff_cap);

   always_comb begin
      free_mask = ~valid_ff;
      if (evict) free_mask[vic_idx_ff] = 1'b1;
      free_ok = 1'b0;
      free_idx = '0;
      for (int i = Entries - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            free_ok = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   // Write-back data for a hit or a new entry.
   logic [UseW-1:0] cnt_inc;
   assign cnt_inc = (found_ent_ff.count == '1) ? found_ent_ff.count
                                                : found_ent_ff.count + UseW'(1);

   always_comb begin
      wr_en = 1'b0;
      wr_addr = found_idx_ff;
      wr_data = found_ent_ff;
      if (state_ff == S_WRITE) begin
         if (found_ff) begin
            wr_en = 1'b1;
            wr_data.count = cnt_inc;
            wr_data.stamp = clock_ff + StampW'(1);
            if (req_ff.operation == OP_SET) wr_data.data = req_ff.value;
         end else if (req_ff.operation == OP_SET && free_ok) begin
            wr_en = 1'b1;
            wr_addr = free_idx;
            wr_data.key = req_ff.key;
            wr_data.data = req_ff.value;
            wr_data.count = UseW'(1);
            wr_data.stamp = clock_ff + StampW'(1);
         end
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // Control: sweep the memory, then update, then hold the response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         clock_ff <= '0;
         occ_ff <= '0;
         rsp_valid_ff <= 1'b0;
         addr_ff <= '0;
         chk_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         vic_ok_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  req_ff <= req.payload;
                  addr_ff <= '0;
                  chk_valid_ff <= 1'b0;
                  found_ff <= 1'b0;
                  vic_ok_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // Entry addr_ff is being read while chk_ff is compared.
               chk_ff <= addr_ff;
               chk_valid_ff <= (32'(addr_ff) < Entries);
               if (32'(addr_ff) < Entries) addr_ff <= addr_ff + (IdxW+1)'(1);
               if (chk_live) begin
                  if (!found_ff && rd_data_ff.key == req_ff.key) begin
                     found_ff <= 1'b1;
                     found_idx_ff <= chk_idx;
                     found_ent_ff <= rd_data_ff;
                  end
                  if (better) begin
                     vic_ok_ff <= 1'b1;
                     vic_idx_ff <= chk_idx;
                     vic_cnt_ff <= rd_data_ff.count;
                     vic_stamp_ff <= rd_data_ff.stamp;
                  end
               end
               if (chk_valid_ff && 32'(chk_ff) == Entries - 1) state_ff <= S_WRITE;
            end
            S_WRITE: begin
               rsp_ff.hit <= found_ff;
               if (found_ff) begin
                  clock_ff <= clock_ff + StampW'(1);
                  rsp_ff.read_value <= (req_ff.operation == OP_GET) ?
                                       found_ent_ff.data : '0;
               end else begin
                  rsp_ff.read_value <= (req_ff.operation == OP_GET) ? '1 : '0;
                  if (req_ff.operation == OP_SET) begin
                     if (free_ok) begin
                        valid_ff <= (evict ? (valid_ff & ~(Entries'(1) << vic_idx_ff))
                                           : valid_ff) | (Entries'(1) << free_idx);
                        clock_ff <= clock_ff + StampW'(1);
                        occ_ff <= evict ? occ_ff : occ_ff + CntW'(1);
                     end else if (evict) begin
                        valid_ff <= valid_ff & ~(Entries'(1) << vic_idx_ff);
                        occ_ff <= occ_ff - CntW'(1);
                     end
                  end
               end
               rsp_valid_ff <= 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
